// ----- rtl/osrq_pkg.sv -----
// Package for the ordered set rank query block.
// Holds field widths, item codes and the control struct shared by the cell chain.
// No dependencies.
package osrq_pkg;

   localparam int KEY_WIDTH    = 32;
   localparam int STATUS_WIDTH = 3;
   localparam int RANK_WIDTH   = 9;

   typedef logic signed [KEY_WIDTH-1:0]  key_type;
   typedef logic [STATUS_WIDTH-1:0]      status_type;
   typedef logic [RANK_WIDTH-1:0]        rank_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam status_type STATUS_INSERTED = 3'd0;
   localparam status_type STATUS_PRESENT  = 3'd1;
   localparam status_type STATUS_FULL     = 3'd2;
   localparam status_type STATUS_FOUND    = 3'd3;
   localparam status_type STATUS_MISSING  = 3'd4;

   // Broadcast control for every cell of the chain.
   typedef struct packed {
      logic compare;   // capture the compare flags against the broadcast key
      logic commit;    // insert the broadcast key, shifting larger keys up
   } cell_ctrl_type;

endpackage

// ----- rtl/osrq_req_if.sv -----
// Request channel interface: valid/ready handshake with op and key.
// Depends on osrq_pkg.
interface osrq_req_if import osrq_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    op;
   key_type key;

   modport source (output valid, output op, output key, input ready);
   modport sink   (input valid, input op, input key, output ready);
endinterface

// ----- rtl/osrq_rsp_if.sv -----
// Response channel interface: valid/ready handshake with status and rank.
// Depends on osrq_pkg.
interface osrq_rsp_if import osrq_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   rank_type   rank;

   modport source (output valid, output status, output rank, input ready);
   modport sink   (input valid, input status, input rank, output ready);
endinterface

// ----- rtl/osrq_cell.sv -----
// One cell of the sorted key chain: a stored key, its valid bit and compare flags.
// Depends on osrq_pkg.
module osrq_cell import osrq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  key_type       bcast_key,
   input  key_type       prev_key,
   input  logic          prev_valid,
   input  logic          prev_lt,
   output key_type       key,
   output logic          valid,
   output logic          lt,
   output logic          eq
);

   key_type key_ff;
   logic    valid_ff;
   logic    lt_ff;
   logic    eq_ff;
   logic    lt_in;
   logic    eq_in;

   assign lt_in = valid_ff && (key_ff < bcast_key);
   assign eq_in = valid_ff && (key_ff == bcast_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         if (ctrl.compare) begin
            lt_ff <= lt_in;
            eq_ff <= eq_in;
         end
         // Cells holding smaller keys keep them; the first other cell takes the
         // new key and every cell above it takes its lower neighbour's contents.
         if (ctrl.commit && !lt_ff) begin
            if (prev_lt) begin
               valid_ff <= 1'b1;
            end else begin
               valid_ff <= prev_valid;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit && !lt_ff) begin
         if (prev_lt) begin
            key_ff <= bcast_key;
         end else begin
            key_ff <= prev_key;
         end
      end
   end

   assign key   = key_ff;
   assign valid = valid_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

// ----- rtl/osrq_encode.sv -----
// Match encoder: turns the one-hot equality flags of the chain into a hit and its index.
// No dependencies.
module osrq_encode #(
   parameter int CAPACITY = 256
) (
   input  logic [CAPACITY-1:0]         eq_flags,
   output logic                        hit,
   output logic [$clog2(CAPACITY)-1:0] index
);

   localparam int IDX_W = $clog2(CAPACITY);

   // Keys are distinct, so at most one flag is set and an OR of indexes is exact.
   always_comb begin
      index = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (eq_flags[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

   assign hit = |eq_flags;

endmodule

// ----- rtl/ordered_set_rank_query.sv -----
// Ordered set with descending rank queries, built as a sorted chain of key cells.
// The request key is registered, compared in the cells in the compare state, then resolved
// and committed in the resolve state, where the result is registered for the receiver.
// A new item can be accepted in the resolve state of the previous one, while it commits,
// unless the response register is still held by a stalled result.
// Reset clears the state machine, the cell valid bits, the fill count and the
// response valid; stored keys need no clearing, so the block is ready at once.
module ordered_set_rank_query import osrq_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input logic        clock,
   input logic        reset,
   osrq_req_if.sink   req_chan,
   osrq_rsp_if.source rsp_chan
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int OCC_W  = $clog2(CAPACITY + 1);
   localparam int DIFF_W = (OCC_W > RANK_WIDTH) ? OCC_W : RANK_WIDTH;

   // Sequencer states: waiting, compare in the cells, reduce and commit.
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_COMPARE = 2'd1;
   localparam logic [1:0] ST_RESOLVE = 2'd2;

   logic [1:0]       state_ff;
   logic [1:0]       state_in;
   logic             op_ff;
   key_type          key_ff;
   logic [OCC_W-1:0] occupancy_ff;
   logic             rsp_valid_ff;
   status_type       status_ff;
   rank_type         rank_ff;

   logic             accept;
   logic             out_free;
   logic             resolve_go;
   logic             present;
   logic             full;
   logic             do_insert;
   logic [IDX_W-1:0] hit_index;
   logic [DIFF_W-1:0] rank_wide;
   status_type       status_in;
   rank_type         rank_in;
   cell_ctrl_type    ctrl;

   key_type           cell_key   [CAPACITY];
   logic [CAPACITY-1:0] cell_valid;
   logic [CAPACITY-1:0] cell_lt;
   logic [CAPACITY-1:0] cell_eq;

   // The response register is free when empty or being emptied in this cycle.
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign resolve_go = (state_ff == ST_RESOLVE) && out_free;

   // A new item may enter while the previous one commits, because its compare
   // cycle follows the commit edge and so sees the updated chain.
   assign req_chan.ready = (state_ff == ST_IDLE) || resolve_go;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            if (out_free) begin
               state_in = accept ? ST_COMPARE : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_chan.op;
         key_ff <= req_chan.key;
      end
   end

   // The chain of cells, each handing its key and flags up to the next one.
   assign ctrl.compare = (state_ff == ST_COMPARE);
   assign ctrl.commit  = resolve_go && do_insert;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         osrq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .bcast_key  (key_ff),
            .prev_key   (key_ff),
            .prev_valid (1'b0),
            .prev_lt    (1'b1),
            .key        (cell_key[i]),
            .valid      (cell_valid[i]),
            .lt         (cell_lt[i]),
            .eq         (cell_eq[i])
         );
      end else begin : g_next
         osrq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .bcast_key  (key_ff),
            .prev_key   (cell_key[i-1]),
            .prev_valid (cell_valid[i-1]),
            .prev_lt    (cell_lt[i-1]),
            .key        (cell_key[i]),
            .valid      (cell_valid[i]),
            .lt         (cell_lt[i]),
            .eq         (cell_eq[i])
         );
      end
   end

   osrq_encode #(
      .CAPACITY (CAPACITY)
   ) u_encode (
      .eq_flags (cell_eq),
      .hit      (present),
      .index    (hit_index)
   );

   // Cell i holds the key with descending rank occupancy - i.
   assign full      = (occupancy_ff == OCC_W'(CAPACITY));
   assign do_insert = (op_ff == OP_INSERT) && !present && !full;
   assign rank_wide = DIFF_W'(occupancy_ff) - DIFF_W'(hit_index);

   always_comb begin
      rank_in = '0;
      if (op_ff == OP_INSERT) begin
         if (present) begin
            status_in = STATUS_PRESENT;
         end else if (full) begin
            status_in = STATUS_FULL;
         end else begin
            status_in = STATUS_INSERTED;
         end
      end else begin
         if (present) begin
            status_in = STATUS_FOUND;
            rank_in   = rank_wide[RANK_WIDTH-1:0];
         end else begin
            status_in = STATUS_MISSING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.commit) begin
            occupancy_ff <= occupancy_ff + OCC_W'(1);
         end
         if (resolve_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (resolve_go) begin
         status_ff <= status_in;
         rank_ff   <= rank_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.rank   = rank_ff;

endmodule

// ----- rtl/osrq_check.sv -----
// Port-level checker for the ordered set rank query block, and its bind.
// Depends on osrq_pkg and on the top level ordered_set_rank_query.
module osrq_check import osrq_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input status_type rsp_status,
   input rank_type   rsp_rank
);

   // Only a found query carries a rank.
   a_rank_only_on_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_FOUND) |-> (rsp_rank == '0))
      else $error("rank set on a result that is not a found query");

   // A found key always has a rank of at least one.
   a_found_has_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FOUND) |-> (rsp_rank != '0))
      else $error("found query with zero rank");

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_rank))
      else $error("stalled result item changed");

   // A result appears in an empty response register only after an accepted request item.
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("result item without a matching request item");

endmodule

bind ordered_set_rank_query osrq_check u_osrq_check (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_rank   (rsp_chan.rank)
);
